// ===== rtl/planar_video_memory_latch_alu_assert.svh =====
// Assertion macros used by the checker module of the video memory block.
`ifndef PLANAR_VIDEO_MEMORY_LATCH_ALU_ASSERT_SVH
`define PLANAR_VIDEO_MEMORY_LATCH_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVMLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvmla assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVMLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvmla assertion failed");

`endif

// ===== rtl/pvmla_pkg.sv =====
package pvmla_pkg;

    // Default sizing of the memory and the CPU window.
    localparam int PAGE_BYTES_DEF   = 8192;
    localparam int WINDOW_BYTES_DEF = 65536;
    localparam int PLANE_COUNT_DEF  = 4;

    // Fixed field widths.
    localparam int OFFSET_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int MAX_PLANES = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_ROTATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_PLANE  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [3:0] MAP_MASK_RST    = 4'hF;
    localparam logic [4:0] DATA_ROTATE_RST = 5'd0;
    localparam logic [1:0] READ_PLANE_RST  = 2'd0;

    // Byte returned by a read outside the backed pages.
    localparam logic [BYTE_W-1:0] ERR_READ_BYTE = 8'hFF;

    // Logic functions applied between the rotated byte and the latch.
    typedef enum logic [1:0] {
        FN_REPLACE = 2'd0,
        FN_AND     = 2'd1,
        FN_OR      = 2'd2,
        FN_XOR     = 2'd3
    } alu_fn_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic respond;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } ctrl_sts_t;

    // Rotate a byte right by 0 to 7 places.
    function automatic logic [BYTE_W-1:0] rotate_right(input logic [BYTE_W-1:0] v,
                                                       input logic [2:0] n);
        logic [2*BYTE_W-1:0] both;
        both = {v, v} >> n;
        return both[BYTE_W-1:0];
    endfunction

    // Combine the rotated CPU byte with one latch byte.
    function automatic logic [BYTE_W-1:0] alu_combine(input alu_fn_t fn,
                                                      input logic [BYTE_W-1:0] r,
                                                      input logic [BYTE_W-1:0] lat);
        logic [BYTE_W-1:0] res;
        case (fn)
            FN_REPLACE: res = r;
            FN_AND:     res = r & lat;
            FN_OR:      res = r | lat;
            FN_XOR:     res = r ^ lat;
            default:    res = r;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/pvmla_ram.sv =====
module pvmla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: one write and one registered read per cycle, at one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pvmla_datapath.sv =====
module pvmla_datapath
    import pvmla_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int PLANE_COUNT  = PLANE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts,
    input  logic                  req_type,
    input  logic [OFFSET_W-1:0]   window_offset,
    input  logic [BYTE_W-1:0]     write_data,
    output logic [BYTE_W-1:0]     read_data,
    output logic                  out_of_range,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = 2 * PAGE_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [3:0]                        map_mask_reg;
    logic [4:0]                        data_rotate_reg;
    logic [1:0]                        read_plane_reg;
    logic [MAX_PLANES-1:0][BYTE_W-1:0] latch_reg;
    logic [ADDR_W-1:0]                 clr_cnt_reg;
    logic                              is_write_reg;
    logic                              err_reg;
    logic [BYTE_W-1:0]                 read_data_reg;
    logic [BYTE_W-1:0]                 read_data_next;
    logic                              out_of_range_reg;

    logic [OFFSET_W-1:0]               off_masked;
    logic                              in_range;
    logic [ADDR_W-1:0]                 ram_addr;
    logic                              ram_rd_en;
    logic [BYTE_W-1:0]                 rot_byte;
    alu_fn_t                           fn;
    logic [MAX_PLANES-1:0][BYTE_W-1:0] rd_lane;

    // Offset wraps within the window; only two pages are backed.
    assign off_masked = window_offset & OFFSET_W'(WINDOW_BYTES - 1);
    assign in_range   = {1'b0, off_masked} < (OFFSET_W + 1)'(STORE_DEPTH);

    // The clearing pass owns the address until it is finished.
    assign ram_addr  = cmd.clear_wr ? clr_cnt_reg : off_masked[ADDR_W-1:0];
    assign ram_rd_en = cmd.accept && !req_type && in_range;

    assign rot_byte = rotate_right(write_data, data_rotate_reg[2:0]);
    assign fn       = alu_fn_t'(data_rotate_reg[4:3]);

    // One byte-wide memory per plane; absent planes read as zero.
    for (genvar p = 0; p < MAX_PLANES; p++)
    begin : g_plane
        if (p < PLANE_COUNT)
        begin : g_mem
            logic              we;
            logic [BYTE_W-1:0] wdata;

            assign we    = cmd.clear_wr
                           || (cmd.accept && req_type && in_range && map_mask_reg[p]);
            assign wdata = cmd.clear_wr ? '0 : alu_combine(fn, rot_byte, latch_reg[p]);

            pvmla_ram #(
                .WIDTH (BYTE_W),
                .DEPTH (STORE_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (we),
                .rd_en (ram_rd_en),
                .addr  (ram_addr),
                .wdata (wdata),
                .rdata (rd_lane[p])
            );
        end
        else
        begin : g_none
            assign rd_lane[p] = '0;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));

    // Result byte for the request now being answered.
    always_comb
    begin
        if (is_write_reg)
        begin
            read_data_next = '0;
        end
        else if (err_reg)
        begin
            read_data_next = ERR_READ_BYTE;
        end
        else
        begin
            read_data_next = rd_lane[read_plane_reg];
        end
    end

    // Configuration registers, latch and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mask_reg    <= MAP_MASK_RST;
            data_rotate_reg <= DATA_ROTATE_RST;
            read_plane_reg  <= READ_PLANE_RST;
            latch_reg       <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_MASK:    map_mask_reg    <= cfg_data[3:0];
                    REG_DATA_ROTATE: data_rotate_reg <= cfg_data;
                    REG_READ_PLANE:  read_plane_reg  <= cfg_data[1:0];
                    default:         ;
                endcase
            end
            if (cmd.respond && !is_write_reg && !err_reg)
            begin
                latch_reg <= rd_lane;
            end
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Request attributes and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            is_write_reg <= req_type;
            err_reg      <= !in_range;
        end
        if (cmd.respond)
        begin
            read_data_reg    <= read_data_next;
            out_of_range_reg <= err_reg;
        end
    end

    assign read_data    = read_data_reg;
    assign out_of_range = out_of_range_reg;

endmodule

// ===== rtl/pvmla_ctrl.sv =====
module pvmla_ctrl
    import pvmla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd,
    input  ctrl_sts_t sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Commands to the datapath.
    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.clear_wr = (state_reg == S_CLEAR);
    assign cmd.accept   = in_valid && in_ready;
    assign cmd.respond  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    // Next state and output-valid logic.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (cmd.respond)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/planar_video_memory_latch_alu.sv =====
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_ready   req_type, window_offset, write_data
// out       result     out_valid / out_ready read_data, out_of_range
// cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request is accepted and drives the plane memories in S_IDLE, and its result
// is loaded into the output register in S_RESP, from the registered memory read.
// After reset a clearing pass writes zero to all 2*PAGE_BYTES memory rows
// (16384 by default); no request is accepted meanwhile, configuration writes are.
// A held result stalls only the response in S_RESP; the next request is accepted meanwhile.
module planar_video_memory_latch_alu
    import pvmla_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int PLANE_COUNT  = PLANE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [OFFSET_W-1:0]   window_offset,
    input  logic [BYTE_W-1:0]     write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     read_data,
    output logic                  out_of_range,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pvmla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pvmla_datapath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .WINDOW_BYTES (WINDOW_BYTES),
        .PLANE_COUNT  (PLANE_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .window_offset (window_offset),
        .write_data    (write_data),
        .read_data     (read_data),
        .out_of_range  (out_of_range),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

// ===== rtl/pvmla_checker.sv =====
`include "planar_video_memory_latch_alu_assert.svh"

module pvmla_checker
    import pvmla_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] read_data,
    input logic              out_of_range
);

    // A held result keeps its payload.
    `PVMLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(out_of_range))

    // Only one request at a time is between acceptance and the loading of its result.
    `PVMLA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // An out-of-range result is either the read error byte or a write's zero.
    `PVMLA_ASSERT_SAME(a_err_data, clk, rst_n, out_valid && out_of_range, read_data == ERR_READ_BYTE || read_data == '0)

    // A new result is loaded only from S_RESP, where in_ready is low.
    `PVMLA_ASSERT_SAME(a_result_after_req, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind planar_video_memory_latch_alu pvmla_checker u_checker (.*);

// ===== tb/tb_planar_video_memory_latch_alu.sv =====
module tb_planar_video_memory_latch_alu;
    import pvmla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Access codes carried on req_type.
    localparam logic ACC_RD = 1'b0;
    localparam logic ACC_WR = 1'b1;

    // Backed storage: two pages of one 32-bit word per offset.
    localparam int STORE_WORDS = 2 * PAGE_BYTES_DEF;
    localparam int HOT_COUNT   = 8;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 250;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  acc;
        logic [OFFSET_W-1:0]   offset;
        logic [BYTE_W-1:0]     wdata;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  known;
        logic [BYTE_W-1:0]     exp_rdata;
        logic                  exp_oor;
    } dir_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              oor;
    } bus_resp_t;

    // Directed requests and register writes. Responses that are obvious are typed
    // in; the rest come from the predictor.
    localparam int DIR_ROWS = 34;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{ROW_REQ, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h3FFF, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h4000, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'hFF, 1'b1},
        '{ROW_REQ, ACC_RD, 16'hFFFF, 8'hFF, REG_MAP_MASK, 5'd0, 1'b1, 8'hFF, 1'b1},
        '{ROW_REQ, ACC_WR, 16'h4000, 8'hA5, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b1},
        '{ROW_REQ, ACC_WR, 16'hFFFF, 8'hFF, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b1},
        '{ROW_REQ, ACC_WR, 16'h0000, 8'hFF, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'hFF, 1'b0},
        '{ROW_REQ, ACC_WR, 16'h3FFF, 8'h81, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h3FFF, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_DATA_ROTATE, {FN_AND, 3'd1},
          1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'b00101, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_READ_PLANE, 5'd2, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_WR, 16'h3FFF, 8'h03, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h3FFF, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_DATA_ROTATE, {FN_OR, 3'd7},
          1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'b01010, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_READ_PLANE, 5'd3, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_WR, 16'h2AAA, 8'h5A, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h2AAA, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h8000, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'hFF, 1'b1},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_DATA_ROTATE, {FN_XOR, 3'd4},
          1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_WR, 16'h1555, 8'h3C, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h1555, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'd15, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_READ_PLANE, 5'd1, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h0000, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'hC000, 8'h00, REG_MAP_MASK, 5'd0, 1'b1, 8'hFF, 1'b1},
        '{ROW_REQ, ACC_WR, 16'h1555, 8'h3C, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h1555, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, ACC_RD, 16'h0000, 8'h00, REG_DATA_ROTATE, 5'd31, 1'b0, 8'h00, 1'b0},
        '{ROW_REQ, ACC_WR, 16'h0001, 8'h80, REG_MAP_MASK, 5'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_REQ, ACC_RD, 16'h0001, 8'h00, REG_MAP_MASK, 5'd0, 1'b0, 8'h00, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [OFFSET_W-1:0]   window_offset;
    logic [BYTE_W-1:0]     write_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     read_data;
    logic                  out_of_range;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: plane words, latches and register copies.
    logic [31:0]           mem_words [STORE_WORDS];
    logic [31:0]           latch_word;
    logic [3:0]            cur_mask;
    logic [4:0]            cur_rotate;
    logic [1:0]            cur_plane;

    bus_resp_t             expected_responses [$];
    logic [OFFSET_W-1:0]   hot_offsets [HOT_COUNT];
    int                    mismatch_count;
    int                    requests_accepted;
    int                    burst_left;
    bit                    req_held;
    bit                    cfg_held;

    planar_video_memory_latch_alu u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .window_offset (window_offset),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .out_of_range  (out_of_range),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The run is cut short here if the block stops answering.
    initial
    begin
        #2000000;
        $display("planar_video_memory_latch_alu: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s got %02h, wanted %02h", $realtime, what, got, want);
    endtask

    // Work out the response to one request and update the plane words and latches.
    task automatic compute_bus_response(input logic acc, input logic [OFFSET_W-1:0] off,
                                        input logic [BYTE_W-1:0] wd,
                                        output bus_resp_t resp);
        int unsigned       addr;
        logic [BYTE_W-1:0] rot_byte;
        logic [BYTE_W-1:0] lat;
        logic [BYTE_W-1:0] lane;
        logic [31:0]       word;
        int                i;
        addr = int'(off) & (WINDOW_BYTES_DEF - 1);
        resp = '0;
        if (addr >= STORE_WORDS)
        begin
            // Beyond the backed pages: flag it, reads return all ones.
            resp.oor = 1'b1;
            if (acc == ACC_RD)
                resp.rdata = ERR_READ_BYTE;
        end
        else if (acc == ACC_RD)
        begin
            latch_word = mem_words[addr];
            resp.rdata = latch_word[8*cur_plane +: 8];
        end
        else
        begin
            for (i = 0; i < BYTE_W; i++)
                rot_byte[i] = wd[(i + cur_rotate[2:0]) % BYTE_W];
            word = mem_words[addr];
            for (i = 0; i < PLANE_COUNT_DEF; i++)
            begin
                lat = latch_word[8*i +: 8];
                case (alu_fn_t'(cur_rotate[4:3]))
                    FN_AND:  lane = rot_byte & lat;
                    FN_OR:   lane = rot_byte | lat;
                    FN_XOR:  lane = rot_byte ^ lat;
                    default: lane = rot_byte;
                endcase
                if (cur_mask[i])
                    word[8*i +: 8] = lane;
            end
            mem_words[addr] = word;
        end
    endtask

    // Offer one request; the sender works in bursts with short gaps between them.
    task automatic send_request(input logic acc, input logic [OFFSET_W-1:0] off,
                                input logic [BYTE_W-1:0] wd, input bit typed,
                                input bus_resp_t typed_resp);
        bus_resp_t resp;
        if (cfg_held)
        begin
            cfg_valid <= 1'b0;
            cfg_held = 1'b0;
        end
        if (req_held && burst_left == 0)
        begin
            in_valid <= 1'b0;
            req_held = 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        in_valid      <= 1'b1;
        req_type      <= acc;
        window_offset <= off;
        write_data    <= wd;
        req_held = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        requests_accepted++;
        compute_bus_response(acc, off, wd, resp);
        expected_responses.push_back(typed ? typed_resp : resp);
    endtask

    // Register writes wait until every outstanding request has been answered.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        if (req_held)
        begin
            in_valid <= 1'b0;
            req_held = 1'b0;
            burst_left = 0;
        end
        while (expected_responses.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_held = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAP_MASK:    cur_mask   = val[3:0];
            REG_DATA_ROTATE: cur_rotate = val[4:0];
            REG_READ_PLANE:  cur_plane  = val[1:0];
            default: ;
        endcase
    endtask

    // Response checker: every accepted result is matched with the oldest expectation.
    always @(posedge clk)
    begin
        bus_resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_responses.size() == 0)
                report_mismatch("unexpected response, read_data", read_data, 8'h00);
            else
            begin
                want = expected_responses.pop_front();
                if (read_data !== want.rdata)
                    report_mismatch("read_data", read_data, want.rdata);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", {7'b0, out_of_range}, {7'b0, want.oor});
            end
        end
    end

    // Receiver: stretches of steady, random and periodic readiness, plus one long
    // hold-off part way through so that the block backs up into its input.
    initial
    begin
        int  stretch_left;
        int  mode;
        int  tick;
        int  hold_left;
        bit  hold_done;
        stretch_left = 0;
        mode = 0;
        tick = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && requests_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(20, 80);
                end
                stretch_left--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, then phases of random requests.
    initial
    begin
        bus_resp_t           typed_resp;
        logic [OFFSET_W-1:0] off;
        logic                acc;
        int                  pick;
        int                  ph;
        int                  n;
        in_valid      <= 1'b0;
        req_type      <= ACC_RD;
        window_offset <= '0;
        write_data    <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_MAP_MASK;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        mismatch_count = 0;
        requests_accepted = 0;
        burst_left = 0;
        req_held = 1'b0;
        cfg_held = 1'b0;
        for (n = 0; n < STORE_WORDS; n++)
            mem_words[n] = '0;
        latch_word = '0;
        cur_mask   = MAP_MASK_RST;
        cur_rotate = DATA_ROTATE_RST;
        cur_plane  = READ_PLANE_RST;
        // A few offsets that random requests keep returning to, both ends included.
        hot_offsets[0] = 16'h0000;
        hot_offsets[1] = OFFSET_W'(STORE_WORDS - 1);
        for (n = 2; n < HOT_COUNT; n++)
            hot_offsets[n] = OFFSET_W'($urandom_range(0, STORE_WORDS - 1));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (DIRECTED[n].kind == ROW_CFG)
                write_reg(DIRECTED[n].reg_idx, DIRECTED[n].reg_val);
            else
            begin
                typed_resp.rdata = DIRECTED[n].exp_rdata;
                typed_resp.oor   = DIRECTED[n].exp_oor;
                send_request(DIRECTED[n].acc, DIRECTED[n].offset, DIRECTED[n].wdata,
                             DIRECTED[n].known, typed_resp);
            end
        end

        // Random phases: the first two use the extreme register settings.
        typed_resp = '0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(REG_MAP_MASK, 5'd0);
                write_reg(REG_DATA_ROTATE, 5'd0);
                write_reg(REG_READ_PLANE, 5'd3);
            end
            else if (ph == 1)
            begin
                write_reg(REG_MAP_MASK, 5'd15);
                write_reg(REG_DATA_ROTATE, 5'd31);
                write_reg(REG_READ_PLANE, 5'd0);
            end
            else
            begin
                write_reg(REG_MAP_MASK, CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(REG_DATA_ROTATE, CFG_DATA_W'($urandom_range(0, 31)));
                write_reg(REG_READ_PLANE, CFG_DATA_W'($urandom_range(0, 3)));
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly hot-offset reads and writes, so latch loads feed later writes;
                // the rest goes to the backed pages or to anywhere in the window.
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    acc = ACC_RD;
                    off = hot_offsets[$urandom_range(0, HOT_COUNT - 1)];
                end
                else if (pick < 80)
                begin
                    acc = ACC_WR;
                    off = hot_offsets[$urandom_range(0, HOT_COUNT - 1)];
                end
                else if (pick < 90)
                begin
                    acc = 1'($urandom_range(0, 1));
                    off = OFFSET_W'($urandom_range(0, STORE_WORDS - 1));
                end
                else
                begin
                    acc = 1'($urandom_range(0, 1));
                    off = OFFSET_W'($urandom_range(0, 65535));
                end
                send_request(acc, off, BYTE_W'($urandom_range(0, 255)), 1'b0, typed_resp);
            end
        end

        // Drain the outstanding responses and give the block a few idle cycles.
        if (req_held)
            in_valid <= 1'b0;
        if (cfg_held)
            cfg_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("planar_video_memory_latch_alu: match");
        else
            $display("planar_video_memory_latch_alu: mismatch");
        $finish;
    end

endmodule
